>>> hdl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// shared types and constants of the running sample statistics block
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 25;
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 55;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 47;
    localparam int SD_W     = 32;
    localparam int CONF_W   = 32;

    // shared arithmetic unit sizes
    localparam int MUL_W    = 80;
    localparam int MULB_W   = 40;
    localparam int DVD_W    = 96;
    localparam int DVS_W    = 49;
    localparam int QUO_W    = 64;
    localparam int STEP_W   = 7;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;

    localparam logic [COUNT_W-1:0]       COUNT_MAX = 25'h100_0000;
    localparam logic [SQ_W-1:0]          SQ_MAX    = 55'h40_0000_0000_0000;
    localparam logic [VAR_W-1:0]         VAR_MAX   = 47'h4000_0000_0000;
    localparam logic signed [SUM_W-1:0]  SUM_MAX   = 40'sh7F_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0]  SUM_MIN   = 40'sh80_0000_0000;
    localparam logic signed [SAMPLE_W-1:0] EMPTY_MIN = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] EMPTY_MAX = 16'sh8000;
    // round(1.96 * 2^16)
    localparam logic [16:0]              K196      = 17'd128451;

    localparam logic [STEP_W-1:0] MEAN_STEPS = 7'd56;
    localparam logic [STEP_W-1:0] VAR_STEPS  = 7'd96;
    localparam logic [STEP_W-1:0] CONF_STEPS = 7'd49;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_MERGE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_HOLD  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        JOB_NONE = 4'd0,
        JOB_NQ   = 4'd1,
        JOB_SS   = 4'd2,
        JOB_NN   = 4'd3,
        JOB_MEAN = 4'd4,
        JOB_VAR  = 4'd5,
        JOB_SD   = 4'd6,
        JOB_RN   = 4'd7,
        JOB_KSD  = 4'd8,
        JOB_CONF = 4'd9
    } job_t;

    typedef struct packed {
        logic accept;
        logic init_res;
        logic start;
        job_t job;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic empty;
        logic var_neg;
    } stat_t;

endpackage

>>> hdl/rss_mul.sv
// ----------------------------------------------------------------------------
// rss_mul
// shift-add multiplier, one multiplier bit per cycle, stops when bits run out
// ----------------------------------------------------------------------------
module rss_mul
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_W-1:0]  mcand,
    input  logic [MULB_W-1:0] mplier,
    output logic              done,
    output logic [MUL_W-1:0]  prod
);

    logic              busy_reg;
    logic              done_reg;
    logic [MUL_W-1:0]  a_reg;
    logic [MULB_W-1:0] b_reg;
    logic [MUL_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (b_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= mcand;
            b_reg   <= mplier;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[MUL_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MULB_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> hdl/rss_div.sv
// ----------------------------------------------------------------------------
// rss_div
// restoring divider, one quotient bit per cycle, dividend left aligned
// ----------------------------------------------------------------------------
module rss_div
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dvd,
    input  logic [DVS_W-1:0]  dvs,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [QUO_W-1:0]  quo,
    output logic              big
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              big_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dvd;
            dvs_reg <= dvs;
            rem_reg <= '0;
            quo_reg <= '0;
            big_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            // quotient bits past the register width only mean saturation
            big_reg <= big_reg | quo_reg[QUO_W-1];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign big  = big_reg;

endmodule

>>> hdl/rss_sqrt.sv
// ----------------------------------------------------------------------------
// rss_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module rss_sqrt
    import rss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  rad,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W-1:0]  x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W+1:0]  shifted;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    assign shifted = {rem_reg, x_reg[RAD_W-1:RAD_W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> hdl/rss_datapath.sv
// ----------------------------------------------------------------------------
// rss_datapath
// accumulator registers, shared multiplier, divider and square root, results
// ----------------------------------------------------------------------------
module rss_datapath
    import rss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    input  logic [1:0]                 op,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [COUNT_W-1:0]         part_count,
    input  logic signed [SUM_W-1:0]    part_sum,
    input  logic [SQ_W-1:0]            part_sumsq,
    input  logic signed [SAMPLE_W-1:0] part_min,
    input  logic signed [SAMPLE_W-1:0] part_max,
    output logic [COUNT_W-1:0]         total_count,
    output logic signed [SUM_W-1:0]    total_sum,
    output logic [SQ_W-1:0]            total_sumsq,
    output logic signed [SAMPLE_W-1:0] min_seen,
    output logic signed [SAMPLE_W-1:0] max_seen,
    output logic signed [MEAN_W-1:0]   mean_q16,
    output logic [VAR_W-1:0]           variance_q16,
    output logic [SD_W-1:0]            stddev_q16,
    output logic [CONF_W-1:0]          conf95_q16,
    output logic                       overflow
);

    // accumulator state
    logic [COUNT_W-1:0]         cnt_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic                       flag_reg;

    // intermediate and derived results
    logic [MUL_W-1:0]  a_reg;
    logic [MUL_W-1:0]  b_reg;
    logic [DVS_W-1:0]  nn_reg;
    logic [DVS_W-1:0]  pk_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [VAR_W-1:0]  var_reg;
    logic [SD_W-1:0]   sd_reg;
    logic [ROOT_W-1:0] rootn_reg;
    logic [CONF_W-1:0] conf_reg;

    // accumulate path
    logic [COUNT_W-1:0]         cnt_add;
    logic signed [SUM_W-1:0]    sum_add;
    logic [SQ_W-1:0]            sq_add;
    logic signed [SAMPLE_W-1:0] lo_in;
    logic signed [SAMPLE_W-1:0] hi_in;
    logic signed [31:0]         samp_sq;
    logic [COUNT_W:0]           cnt_sum;
    logic [SUM_W:0]             sum_sum;
    logic [SQ_W:0]              sq_sum;
    logic                       cnt_sat;
    logic                       sum_sat_hi;
    logic                       sum_sat_lo;
    logic                       sq_sat;
    logic [SUM_W-1:0]           smag;
    logic [MUL_W-1:0]           diff_ab;

    // shared units
    logic              mul_start;
    logic              div_start;
    logic              sqrt_start;
    logic [MUL_W-1:0]  mul_a;
    logic [MULB_W-1:0] mul_b;
    logic              mul_done;
    logic [MUL_W-1:0]  mul_p;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic [STEP_W-1:0] div_steps;
    logic              div_done;
    logic [QUO_W-1:0]  div_q;
    logic              div_big;
    logic [RAD_W-1:0]  sqrt_x;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_r;
    logic [31:0]       mean_mag;

    assign samp_sq = sample * sample;

    always_comb
    begin
        cnt_add = '0;
        sum_add = '0;
        sq_add  = '0;
        lo_in   = EMPTY_MIN;
        hi_in   = EMPTY_MAX;
        case (op_t'(op))
            OP_ADD:
            begin
                cnt_add = COUNT_W'(1);
                sum_add = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
                sq_add  = {{(SQ_W-32){1'b0}}, samp_sq};
                lo_in   = sample;
                hi_in   = sample;
            end
            OP_MERGE:
            begin
                cnt_add = part_count;
                sum_add = part_sum;
                sq_add  = part_sumsq;
                lo_in   = part_min;
                hi_in   = part_max;
            end
            default:
            begin
                cnt_add = '0;
            end
        endcase
    end

    assign cnt_sum    = {1'b0, cnt_reg} + {1'b0, cnt_add};
    assign cnt_sat    = cnt_sum > {1'b0, COUNT_MAX};
    assign sum_sum    = {sum_reg[SUM_W-1], sum_reg} + {sum_add[SUM_W-1], sum_add};
    assign sum_sat_hi = !sum_sum[SUM_W] && sum_sum[SUM_W-1];
    assign sum_sat_lo = sum_sum[SUM_W] && !sum_sum[SUM_W-1];
    assign sq_sum     = {1'b0, sq_reg} + {1'b0, sq_add};
    assign sq_sat     = sq_sum > {1'b0, SQ_MAX};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
            lo_reg   <= EMPTY_MIN;
            hi_reg   <= EMPTY_MAX;
            flag_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if ((op_t'(op) == OP_ADD) || (op_t'(op) == OP_MERGE))
            begin
                cnt_reg <= cnt_sat ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
                if (sum_sat_hi)
                begin
                    sum_reg <= SUM_MAX;
                end
                else if (sum_sat_lo)
                begin
                    sum_reg <= SUM_MIN;
                end
                else
                begin
                    sum_reg <= sum_sum[SUM_W-1:0];
                end
                sq_reg <= sq_sat ? SQ_MAX : sq_sum[SQ_W-1:0];
                if (lo_in < lo_reg)
                begin
                    lo_reg <= lo_in;
                end
                if (hi_in > hi_reg)
                begin
                    hi_reg <= hi_in;
                end
                flag_reg <= flag_reg | cnt_sat | sum_sat_hi | sum_sat_lo | sq_sat;
            end
            else if (op_t'(op) == OP_CLEAR)
            begin
                cnt_reg  <= '0;
                sum_reg  <= '0;
                sq_reg   <= '0;
                lo_reg   <= EMPTY_MIN;
                hi_reg   <= EMPTY_MAX;
                flag_reg <= 1'b0;
            end
        end
    end

    assign smag    = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign diff_ab = a_reg - b_reg;

    // operand selection for the shared units
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_dvd   = '0;
        div_dvs   = '0;
        div_steps = MEAN_STEPS;
        sqrt_x    = '0;
        case (cmd.job)
            JOB_NQ:
            begin
                mul_a = {{(MUL_W-SQ_W){1'b0}}, sq_reg};
                mul_b = {{(MULB_W-COUNT_W){1'b0}}, cnt_reg};
            end
            JOB_SS:
            begin
                mul_a = {{(MUL_W-SUM_W){1'b0}}, smag};
                mul_b = smag;
            end
            JOB_NN:
            begin
                mul_a = {{(MUL_W-COUNT_W){1'b0}}, cnt_reg};
                mul_b = {{(MULB_W-COUNT_W){1'b0}}, cnt_reg};
            end
            JOB_KSD:
            begin
                mul_a = {{(MUL_W-SD_W){1'b0}}, sd_reg};
                mul_b = {{(MULB_W-17){1'b0}}, K196};
            end
            JOB_MEAN:
            begin
                div_dvd   = {smag, {(DVD_W-SUM_W){1'b0}}};
                div_dvs   = {{(DVS_W-COUNT_W){1'b0}}, cnt_reg};
                div_steps = MEAN_STEPS;
            end
            JOB_VAR:
            begin
                div_dvd   = {diff_ab, {(DVD_W-MUL_W){1'b0}}};
                div_dvs   = nn_reg;
                div_steps = VAR_STEPS;
            end
            JOB_CONF:
            begin
                div_dvd   = {pk_reg, {(DVD_W-DVS_W){1'b0}}};
                div_dvs   = {{(DVS_W-ROOT_W){1'b0}}, rootn_reg};
                div_steps = CONF_STEPS;
            end
            JOB_SD:
            begin
                sqrt_x = {1'b0, var_reg, {(RAD_W-VAR_W-1){1'b0}}};
            end
            JOB_RN:
            begin
                sqrt_x = {{(RAD_W-COUNT_W-32){1'b0}}, cnt_reg, 32'd0};
            end
            default:
            begin
                sqrt_x = '0;
            end
        endcase
    end

    assign mul_start  = cmd.start && ((cmd.job == JOB_NQ) || (cmd.job == JOB_SS) ||
                                      (cmd.job == JOB_NN) || (cmd.job == JOB_KSD));
    assign div_start  = cmd.start && ((cmd.job == JOB_MEAN) || (cmd.job == JOB_VAR) ||
                                      (cmd.job == JOB_CONF));
    assign sqrt_start = cmd.start && ((cmd.job == JOB_SD) || (cmd.job == JOB_RN));

    rss_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_p)
    );

    rss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd   (div_dvd),
        .dvs   (div_dvs),
        .steps (div_steps),
        .done  (div_done),
        .quo   (div_q),
        .big   (div_big)
    );

    rss_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sqrt_x),
        .done  (sqrt_done),
        .root  (sqrt_r)
    );

    // magnitude limited to 2^31 so the negative side can reach -2^31
    always_comb
    begin
        if (!sum_reg[SUM_W-1])
        begin
            mean_mag = (div_big || (div_q > 64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
        end
        else
        begin
            mean_mag = (div_big || (div_q > 64'h8000_0000)) ? 32'h8000_0000 : div_q[31:0];
            mean_mag = ~mean_mag + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            nn_reg    <= '0;
            pk_reg    <= '0;
            mean_reg  <= '0;
            var_reg   <= '0;
            sd_reg    <= '0;
            rootn_reg <= '0;
            conf_reg  <= '1;
        end
        else if (cmd.init_res)
        begin
            mean_reg <= '0;
            var_reg  <= '0;
            sd_reg   <= '0;
            conf_reg <= '1;
        end
        else if (stat.done)
        begin
            case (cmd.job)
                JOB_NQ:   a_reg     <= mul_p;
                JOB_SS:   b_reg     <= mul_p;
                JOB_NN:   nn_reg    <= mul_p[DVS_W-1:0];
                JOB_KSD:  pk_reg    <= mul_p[DVS_W-1:0];
                JOB_MEAN: mean_reg  <= mean_mag;
                JOB_VAR:  var_reg   <= (div_big || (div_q > {{(QUO_W-VAR_W){1'b0}}, VAR_MAX}))
                                       ? VAR_MAX : div_q[VAR_W-1:0];
                JOB_SD:   sd_reg    <= sqrt_r;
                JOB_RN:   rootn_reg <= sqrt_r;
                JOB_CONF: conf_reg  <= (div_big || (div_q[QUO_W-1:CONF_W] != '0))
                                       ? '1 : div_q[CONF_W-1:0];
                default:  conf_reg  <= conf_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            total_count  <= cnt_reg;
            total_sum    <= sum_reg;
            total_sumsq  <= sq_reg;
            min_seen     <= lo_reg;
            max_seen     <= hi_reg;
            mean_q16     <= mean_reg;
            variance_q16 <= var_reg;
            stddev_q16   <= sd_reg;
            conf95_q16   <= conf_reg;
            overflow     <= flag_reg;
        end
    end

    assign stat.done    = mul_done | div_done | sqrt_done;
    assign stat.empty   = (cnt_reg == '0);
    assign stat.var_neg = a_reg < b_reg;

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_MAX)
        else $error("sample count above its saturation value");

    a_var_limit: assert property (@(posedge clk) disable iff (!rst_n)
        var_reg <= VAR_MAX)
        else $error("variance above its saturation value");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_done, div_done, sqrt_done}))
        else $error("two arithmetic units finished together");
`endif

endmodule

>>> hdl/rss_ctrl.sv
// ----------------------------------------------------------------------------
// rss_ctrl
// sequencer: accept, accumulate, run the derived-statistics jobs, deliver
// ----------------------------------------------------------------------------
module rss_ctrl
    import rss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CHECK = 12'b0000_0000_0010,
        S_NQ    = 12'b0000_0000_0100,
        S_SS    = 12'b0000_0000_1000,
        S_NN    = 12'b0000_0001_0000,
        S_MEAN  = 12'b0000_0010_0000,
        S_VAR   = 12'b0000_0100_0000,
        S_SD    = 12'b0000_1000_0000,
        S_RN    = 12'b0001_0000_0000,
        S_KSD   = 12'b0010_0000_0000,
        S_CONF  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t job_follow;
    job_t   job_now;
    logic   issued_reg;
    logic   issued_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // job run in each state and the state after it
    always_comb
    begin
        job_now    = JOB_NONE;
        job_follow = S_DONE;
        case (state_reg)
            S_NQ:
            begin
                job_now    = JOB_NQ;
                job_follow = S_SS;
            end
            S_SS:
            begin
                job_now    = JOB_SS;
                job_follow = S_NN;
            end
            S_NN:
            begin
                job_now    = JOB_NN;
                job_follow = S_MEAN;
            end
            S_MEAN:
            begin
                job_now    = JOB_MEAN;
                job_follow = stat.var_neg ? S_SD : S_VAR;
            end
            S_VAR:
            begin
                job_now    = JOB_VAR;
                job_follow = S_SD;
            end
            S_SD:
            begin
                job_now    = JOB_SD;
                job_follow = S_RN;
            end
            S_RN:
            begin
                job_now    = JOB_RN;
                job_follow = S_KSD;
            end
            S_KSD:
            begin
                job_now    = JOB_KSD;
                job_follow = S_CONF;
            end
            S_CONF:
            begin
                job_now    = JOB_CONF;
                job_follow = S_DONE;
            end
            default:
            begin
                job_now = JOB_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.job        = job_now;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.init_res = 1'b1;
                state_next   = stat.empty ? S_DONE : S_NQ;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                if (!issued_reg)
                begin
                    cmd.start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (stat.done)
                begin
                    issued_next = 1'b0;
                    state_next  = job_follow;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new item taken while one is in work");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while still held");

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.done)
        else $error("unit started while a finish is pending");
`endif

endmodule

>>> hdl/running_sample_statistics_top.sv
// timing: on an empty accumulator the check state goes straight to delivery; otherwise
// the shared bit-serial multiplier, divider and square root run up to nine jobs in turn,
// the variance job being skipped when it would be negative (up to 40, 56, 96, 49 and 32 steps each)
// throughput: one item at a time; the next item is taken as soon as the result
// sits in the output register, which waits until the receiver has taken the last one
// reset: asynchronous, clears the accumulator to empty and the handshakes
// ----------------------------------------------------------------------------
// running_sample_statistics_top
// running count, sum, sum of squares, min, max with mean, variance, stddev
// and 95% confidence half-width in Q.16
// ----------------------------------------------------------------------------
module running_sample_statistics_top
    import rss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [COUNT_W-1:0]         part_count,
    input  logic signed [SUM_W-1:0]    part_sum,
    input  logic [SQ_W-1:0]            part_sumsq,
    input  logic signed [SAMPLE_W-1:0] part_min,
    input  logic signed [SAMPLE_W-1:0] part_max,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [COUNT_W-1:0]         total_count,
    output logic signed [SUM_W-1:0]    total_sum,
    output logic [SQ_W-1:0]            total_sumsq,
    output logic signed [SAMPLE_W-1:0] min_seen,
    output logic signed [SAMPLE_W-1:0] max_seen,
    output logic signed [MEAN_W-1:0]   mean_q16,
    output logic [VAR_W-1:0]           variance_q16,
    output logic [SD_W-1:0]            stddev_q16,
    output logic [CONF_W-1:0]          conf95_q16,
    output logic                       overflow
);

    cmd_t  cmd;
    stat_t stat;

    rss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rss_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .sample       (sample),
        .part_count   (part_count),
        .part_sum     (part_sum),
        .part_sumsq   (part_sumsq),
        .part_min     (part_min),
        .part_max     (part_max),
        .total_count  (total_count),
        .total_sum    (total_sum),
        .total_sumsq  (total_sumsq),
        .min_seen     (min_seen),
        .max_seen     (max_seen),
        .mean_q16     (mean_q16),
        .variance_q16 (variance_q16),
        .stddev_q16   (stddev_q16),
        .conf95_q16   (conf95_q16),
        .overflow     (overflow)
    );

endmodule

>>> tb/running_sample_statistics_top_test.sv
// ----------------------------------------------------------------------------
// running_sample_statistics_top_test
// drives add, merge, clear and hold items with random gaps and stalls, and
// checks every result against an independent prediction of all statistics
// ----------------------------------------------------------------------------
module running_sample_statistics_top_test;
    import rss_pkg::*;

    localparam int           WATCHDOG_LIMIT = 20000;
    localparam int           RANDOM_ITEMS   = 1700;
    localparam int           LONG_HOLD      = 4000;
    localparam longint       SUM_HI         = 64'sd549755813887;
    localparam longint       SUM_LO         = -64'sd549755813888;
    localparam logic [63:0]  CNT_LIM        = 64'h100_0000;
    localparam logic [63:0]  SQ_LIM         = 64'h40_0000_0000_0000;
    localparam logic [127:0] VAR_LIM        = 128'h4000_0000_0000;
    localparam logic [127:0] K_CONF         = 128'd128451;

    typedef struct {
        logic [COUNT_W-1:0]         cnt;
        logic signed [SUM_W-1:0]    sum;
        logic [SQ_W-1:0]            sq;
        logic signed [SAMPLE_W-1:0] mn;
        logic signed [SAMPLE_W-1:0] mx;
        logic signed [MEAN_W-1:0]   mean;
        logic [VAR_W-1:0]           variance;
        logic [SD_W-1:0]            sd;
        logic [CONF_W-1:0]          conf;
        logic                       ovf;
    } stats_t;

    class stats_board;
        logic [63:0] acc_count;
        longint      acc_sum;
        logic [63:0] acc_sq;
        longint      acc_min;
        longint      acc_max;
        bit          acc_ovf;
        stats_t      pending[$];
        int          mismatches;
        int          results_seen;

        function new();
            clear_acc();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void clear_acc();
            acc_count = 0;
            acc_sum   = 0;
            acc_sq    = 0;
            acc_min   = 32767;
            acc_max   = -32768;
            acc_ovf   = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'h1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void fold_in(logic [63:0] c, longint s, logic [63:0] q, longint lo, longint hi);
            longint ns;
            if (c > CNT_LIM - acc_count)
            begin
                acc_count = CNT_LIM;
                acc_ovf   = 1;
            end
            else
                acc_count = acc_count + c;
            ns = acc_sum + s;
            if (ns > SUM_HI)
            begin
                ns      = SUM_HI;
                acc_ovf = 1;
            end
            if (ns < SUM_LO)
            begin
                ns      = SUM_LO;
                acc_ovf = 1;
            end
            acc_sum = ns;
            if (acc_sq > SQ_LIM || q > SQ_LIM - acc_sq)
            begin
                acc_sq  = SQ_LIM;
                acc_ovf = 1;
            end
            else
                acc_sq = acc_sq + q;
            if (lo < acc_min)
                acc_min = lo;
            if (hi > acc_max)
                acc_max = hi;
        endfunction

        function void note_input(logic [1:0] op_code, logic signed [15:0] smp,
                                 logic [24:0] pc, logic signed [39:0] ps, logic [54:0] pq,
                                 logic signed [15:0] pmn, logic signed [15:0] pmx);
            stats_t      e;
            logic [63:0] n, smag, quo, rootn, sd;
            logic [127:0] a, b, num, vq, ct;
            longint      v;
            v = smp;
            case (op_t'(op_code))
                OP_ADD:   fold_in(1, v, 64'(v * v), v, v);
                OP_MERGE: fold_in(64'(pc), longint'(ps), 64'(pq), longint'(pmn), longint'(pmx));
                OP_CLEAR: clear_acc();
                default:  ;
            endcase
            n          = acc_count;
            e.cnt      = n[COUNT_W-1:0];
            e.sum      = acc_sum[SUM_W-1:0];
            e.sq       = acc_sq[SQ_W-1:0];
            e.mn       = acc_min[15:0];
            e.mx       = acc_max[15:0];
            e.ovf      = acc_ovf;
            e.mean     = 0;
            e.variance = 0;
            e.sd       = 0;
            e.conf     = 32'hFFFF_FFFF;
            if (n != 0)
            begin
                smag = acc_sum < 0 ? 64'(-acc_sum) : 64'(acc_sum);
                quo  = (smag << 16) / n;
                if (acc_sum >= 0)
                    e.mean = quo > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : quo[31:0];
                else
                    e.mean = -(quo > 64'h8000_0000 ? 32'h8000_0000 : quo[31:0]);
                a = 128'(n) * 128'(acc_sq);
                b = 128'(smag) * 128'(smag);
                if (a < b)
                    vq = 0;
                else
                begin
                    num = (a - b) << 16;
                    vq  = num / (128'(n) * 128'(n));
                    if (vq > VAR_LIM)
                        vq = VAR_LIM;
                end
                e.variance = vq[VAR_W-1:0];
                sd         = int_sqrt(vq[63:0] << 16);
                e.sd       = sd[31:0];
                rootn      = int_sqrt(n << 32);
                ct         = (128'(sd) * K_CONF) / 128'(rootn);
                e.conf     = ct > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : ct[31:0];
            end
            pending.push_back(e);
        endfunction

        function void check_result(stats_t got);
            stats_t e;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: count %0d", $realtime, got.cnt);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at %0t\n  exp cnt %0d sum %0d sq %0d min %0d max %0d",
                              " mean %0d var %0d sd %0d conf %0d ovf %0d\n",
                              "  got cnt %0d sum %0d sq %0d min %0d max %0d",
                              " mean %0d var %0d sd %0d conf %0d ovf %0d"}, $realtime,
                             e.cnt, e.sum, e.sq, e.mn, e.mx, e.mean, e.variance, e.sd,
                             e.conf, e.ovf, got.cnt, got.sum, got.sq, got.mn, got.mx,
                             got.mean, got.variance, got.sd, got.conf, got.ovf);
            end
        endfunction
    endclass

    logic                       clk = 0;
    logic                       rst_n = 0;
    logic                       in_valid = 0;
    logic                       in_ready;
    logic [1:0]                 op = OP_HOLD;
    logic signed [SAMPLE_W-1:0] sample = 0;
    logic [COUNT_W-1:0]         part_count = 0;
    logic signed [SUM_W-1:0]    part_sum = 0;
    logic [SQ_W-1:0]            part_sumsq = 0;
    logic signed [SAMPLE_W-1:0] part_min = 0;
    logic signed [SAMPLE_W-1:0] part_max = 0;
    logic                       out_valid;
    logic                       out_ready = 0;
    stats_t                     got;
    stats_board                 board = new();
    int                         idle_cycles = 0;
    int                         hold_left = 0;
    bit                         hold_done = 0;
    bit                         no_gaps = 0;
    int                         sent = 0;

    running_sample_statistics_top u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .sample(sample), .part_count(part_count), .part_sum(part_sum),
        .part_sumsq(part_sumsq), .part_min(part_min), .part_max(part_max),
        .out_valid(out_valid), .out_ready(out_ready), .total_count(got.cnt),
        .total_sum(got.sum), .total_sumsq(got.sq), .min_seen(got.mn), .max_seen(got.mx),
        .mean_q16(got.mean), .variance_q16(got.variance), .stddev_q16(got.sd),
        .conf95_q16(got.conf), .overflow(got.ovf)
    );

    always #4 clk = ~clk;

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // monitor, scoreboard feed and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(got);
            if (in_valid && in_ready)
                board.note_input(op, sample, part_count, part_sum, part_sumsq, part_min, part_max);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off to fill the block
    always @(posedge clk)
    begin
        if (!hold_done && board.results_seen >= 300)
        begin
            hold_done <= 1;
            hold_left <= LONG_HOLD;
            out_ready <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 0;
        end
        else if (no_gaps)
            out_ready <= 1;
        else
            out_ready <= $urandom_range(0, 99) < 70;
    end

    task automatic send_item(logic [1:0] o, logic signed [15:0] s, logic [24:0] pc,
                             logic signed [39:0] ps, logic [54:0] pq,
                             logic signed [15:0] pmn, logic signed [15:0] pmx);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid   <= 1;
        op         <= o;
        sample     <= s;
        part_count <= pc;
        part_sum   <= ps;
        part_sumsq <= pq;
        part_min   <= pmn;
        part_max   <= pmx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_sample(logic signed [15:0] s);
        send_item(OP_ADD, s, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom, $urandom);
    endtask

    task automatic send_random();
        int r, k;
        logic signed [15:0] lo, hi;
        logic [63:0] sq;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            if ($urandom_range(0, 3) == 0)
                send_sample($urandom);
            else
                send_sample($signed(16'($urandom_range(0, 400))) - 16'sd200);
        end
        else if (r < 80)
        begin
            // plausible partial from a small batch
            k  = $urandom_range(1, 50);
            lo = $urandom_range(0, 2000) - 1000;
            hi = lo + 16'($urandom_range(0, 2000));
            sq = 64'(k) * 64'(longint'(lo) * lo + longint'(hi) * hi) / 2 + 1;
            send_item(OP_MERGE, $urandom, k, 40'(longint'(k) * (lo + hi) / 2), sq[54:0],
                      lo, hi);
        end
        else if (r < 88)
            send_item(OP_MERGE, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom, $urandom);
        else if (r < 95)
            send_item(OP_CLEAR, $urandom, $urandom, {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom, $urandom);
        else
            send_item(OP_HOLD, $urandom, $urandom, {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom, $urandom);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // empty accumulator, then sample extremes
        send_item(OP_HOLD, 0, 0, 0, 0, 0, 0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(0);
        send_sample(1);
        send_sample(-1);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_item(OP_HOLD, 0, 0, 0, 0, 0, 0);
        // inconsistent partial: sum with no samples, then huge sums
        send_item(OP_MERGE, 0, 0, 40'sd12345, 55'd7, 16'sh8000, 16'sh7FFF);
        send_item(OP_MERGE, 0, 25'd3, 40'sd0, 55'd0, 16'sd5, 16'sd5);
        send_item(OP_MERGE, 0, 25'd1, 40'sh7F_FFFF_FFFF, 55'h7F_FFFF_FFFF_FFFF,
                  16'sh7FFF, 16'sh8000);
        send_item(OP_MERGE, 0, 25'd1, 40'sh80_0000_0000, 55'd0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        // count saturation, below and past the limit
        send_item(OP_MERGE, 0, 25'hFF_FFFF, 40'sd0, 55'd0, 0, 0);
        send_sample(16'sd100);
        send_sample(16'sd100);
        send_item(OP_MERGE, 0, 25'h1FF_FFFF, 40'sd0, 55'd0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send_item(OP_MERGE, 0, 25'h100_0000, 40'sh40_0000_0000, 55'h40_0000_0000_0000,
                  16'sh8000, 16'sh7FFF);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // runs of back-to-back traffic now and then
            if (i % 200 == 0)
                no_gaps = (i / 200) % 3 == 1;
            send_random();
        end
        in_valid <= 0;
        no_gaps = 1;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        $display("sent %0d items (add, merge, clear, hold), checked %0d results",
                 sent, board.results_seen);
        $display("covered empty, sample extremes, saturation, bad partials, long stall");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rss_pkg.sv
hdl/rss_mul.sv
hdl/rss_div.sv
hdl/rss_sqrt.sv
hdl/rss_datapath.sv
hdl/rss_ctrl.sv
hdl/running_sample_statistics_top.sv
tb/running_sample_statistics_top_test.sv
